// ----- src/tak_pkg.sv -----
// Shared types, constants and helper functions for the tilt angle Kalman filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tak_pkg;

    localparam int NUM_AXES     = 2;
    localparam int AXW          = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int CORDIC_STEPS = 24;
    localparam int CSW          = $clog2(CORDIC_STEPS);

    localparam int MW  = 50;          // multiplier operand width (signed)
    localparam int MHW = MW / 2;      // partial product operand width
    localparam int MPW = 2 * MW;      // full product width
    localparam int MRW = 64;          // rounded product width (signed)
    localparam int SW  = 66;          // width of sums before saturation
    localparam int PW  = 48;          // covariance and gain width
    localparam int EW  = 35;          // innovation width
    localparam int MEW = 34;          // measured angle width
    localparam int CXW = 34;          // CORDIC x/y width
    localparam int CZW = 38;          // CORDIC angle accumulator width, Q32
    localparam int DIV_BITS = 46;
    localparam int DCW = $clog2(DIV_BITS + 1);

    localparam logic signed [CZW-1:0] PI_Q32 = 38'sd13493037705;
    localparam logic [62:0] MAG_LIM = 63'd1 << 62;
    localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW-1:0] P_ONE = 48'sd70368744177664;

    typedef enum logic [1:0] {
        SH32,
        SH46,
        SH50
    } mul_shift_t;

    typedef enum logic [1:0] {
        REG_PERIOD,
        REG_ANGLE_Q,
        REG_BIAS_Q,
        REG_MEAS_R
    } cfg_reg_t;

    typedef struct packed {
        logic                 start;
        mul_shift_t           sh;
        logic signed [MW-1:0] a;
        logic signed [MW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic signed [PW-1:0] num;
        logic [PW-1:0]        den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [PW-1:0] sat48(input logic signed [SW-1:0] v);
        if (v > 66'sd140737488355327)
            return P_MAX;
        else if (v < -66'sd140737488355328)
            return P_MIN;
        else
            return v[PW-1:0];
    endfunction

    // atan(2^-i) in Q32
    function automatic logic [31:0] atan_step(input logic [CSW-1:0] i);
        logic [31:0] v;
        v = 32'd0;
        unique case (i)
            0:       v = 32'd3373259426;
            1:       v = 32'd1991351318;
            2:       v = 32'd1052175346;
            3:       v = 32'd534100635;
            4:       v = 32'd268086748;
            5:       v = 32'd134174063;
            6:       v = 32'd67103403;
            7:       v = 32'd33553749;
            8:       v = 32'd16777131;
            9:       v = 32'd8388597;
            10:      v = 32'd4194303;
            default:
            begin
                if (int'(i) <= 32)
                    v = 32'd1 << (32 - int'(i));
                else
                    v = 32'd0;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/tak_mul.sv -----
// Shared rounding multiplier: signed 50x50 product over four 25x25 partial products,
// then round to nearest (ties away), shift and magnitude clamp. Uses tak_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tak_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tak_pkg::mul_req_t             req,
    output logic                               done,
    output logic signed [tak_pkg::MRW-1:0]     res
);

    logic                          busy_reg;
    logic [2:0]                    step_reg;
    logic [tak_pkg::MW-1:0]        ma_reg;
    logic [tak_pkg::MW-1:0]        mb_reg;
    logic                          neg_reg;
    tak_pkg::mul_shift_t           sh_reg;
    logic [tak_pkg::MPW-1:0]       acc_reg;
    logic                          done_reg;
    logic signed [tak_pkg::MRW-1:0] res_reg;

    logic [tak_pkg::MHW-1:0]       a_part;
    logic [tak_pkg::MHW-1:0]       b_part;
    logic [2*tak_pkg::MHW-1:0]     pp;
    logic [tak_pkg::MPW-1:0]       pp_sh;
    logic [5:0]                    rshift;
    logic [tak_pkg::MPW:0]         rsum;
    logic [tak_pkg::MPW:0]         rq;
    logic [62:0]                   rmag;
    logic signed [tak_pkg::MRW-1:0] res_next;
    logic [tak_pkg::MW-1:0]        ma_next;
    logic [tak_pkg::MW-1:0]        mb_next;

    always_comb
    begin
        ma_next = req.a[tak_pkg::MW-1] ? unsigned'(-req.a) : unsigned'(req.a);
        mb_next = req.b[tak_pkg::MW-1] ? unsigned'(-req.b) : unsigned'(req.b);
        a_part = step_reg[0] ? ma_reg[tak_pkg::MW-1:tak_pkg::MHW] : ma_reg[tak_pkg::MHW-1:0];
        b_part = step_reg[1] ? mb_reg[tak_pkg::MW-1:tak_pkg::MHW] : mb_reg[tak_pkg::MHW-1:0];
        pp = a_part * b_part;
        unique case (step_reg[1:0])
            2'b00:        pp_sh = tak_pkg::MPW'(pp);
            2'b01, 2'b10: pp_sh = tak_pkg::MPW'(pp) << tak_pkg::MHW;
            default:      pp_sh = tak_pkg::MPW'(pp) << (2 * tak_pkg::MHW);
        endcase
        unique case (sh_reg)
            tak_pkg::SH32: rshift = 6'd32;
            tak_pkg::SH46: rshift = 6'd46;
            default:       rshift = 6'd50;
        endcase
        rsum = {1'b0, acc_reg} + ((tak_pkg::MPW + 1)'(1) << (rshift - 6'd1));
        rq = rsum >> rshift;
        rmag = (rq > (tak_pkg::MPW + 1)'(tak_pkg::MAG_LIM)) ? tak_pkg::MAG_LIM : rq[62:0];
        res_next = neg_reg ? -signed'({1'b0, rmag}) : signed'({1'b0, rmag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
            end
            else if (step_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
            neg_reg <= req.a[tak_pkg::MW-1] ^ req.b[tak_pkg::MW-1];
            sh_reg  <= req.sh;
            acc_reg <= '0;
        end
        else if (busy_reg && step_reg != 3'd4)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
        else if (busy_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ----- src/tak_div.sv -----
// Gain divider: restoring division, one quotient bit per cycle, Q2.46 result
// truncated toward zero and saturated to [-2,2). Uses tak_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tak_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tak_pkg::div_req_t             req,
    output logic                               done,
    output logic signed [tak_pkg::PW-1:0]      q
);

    logic                           busy_reg;
    logic [tak_pkg::DCW-1:0]        cnt_reg;
    logic [tak_pkg::PW-1:0]         r_reg;
    logic [tak_pkg::PW-1:0]         d_reg;
    logic [tak_pkg::PW-1:0]         q_reg;
    logic                           neg_reg;
    logic                           ovf_reg;
    logic                           done_reg;
    logic signed [tak_pkg::PW-1:0]  q_out_reg;

    logic [tak_pkg::PW-1:0]         n_c;
    logic                           ovf_c;
    logic                           q0_c;
    logic [tak_pkg::PW:0]           r2;
    logic                           ge;
    logic [tak_pkg::PW:0]           rsub;
    logic signed [tak_pkg::PW-1:0]  q_final;
    logic                           last;

    always_comb
    begin
        n_c   = req.num[tak_pkg::PW-1] ? unsigned'(-req.num) : unsigned'(req.num);
        ovf_c = {1'b0, n_c} >= {req.den, 1'b0};
        q0_c  = n_c >= req.den;
        r2    = {r_reg, 1'b0};
        ge    = r2 >= {1'b0, d_reg};
        rsub  = r2 - {1'b0, d_reg};
        last  = cnt_reg == tak_pkg::DCW'(tak_pkg::DIV_BITS);
        if (ovf_reg)
            q_final = neg_reg ? tak_pkg::P_MIN : tak_pkg::P_MAX;
        else
            q_final = neg_reg ? -signed'(q_reg) : signed'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= ovf_c ? tak_pkg::DCW'(tak_pkg::DIV_BITS) : '0;
                end
            end
            else if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + tak_pkg::DCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            d_reg   <= req.den;
            neg_reg <= req.num[tak_pkg::PW-1];
            ovf_reg <= ovf_c;
            q_reg   <= tak_pkg::PW'(q0_c);
            r_reg   <= q0_c ? n_c - req.den : n_c;
        end
        else if (busy_reg && !last)
        begin
            r_reg <= ge ? rsub[tak_pkg::PW-1:0] : r2[tak_pkg::PW-1:0];
            q_reg <= {q_reg[tak_pkg::PW-2:0], ge};
        end
        else if (busy_reg)
        begin
            q_out_reg <= q_final;
        end
    end

    assign done = done_reg;
    assign q    = q_out_reg;

endmodule

`default_nettype wire

// ----- src/tak_cordic.sv -----
// Vectoring CORDIC: atan2(-lateral, vertical) in Q4.28, one rotation per cycle.
// Uses tak_pkg for the step count and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module tak_cordic (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [15:0]            lat,
    input  wire logic signed [15:0]            vert,
    output logic                               done,
    output logic signed [tak_pkg::MEW-1:0]     meas
);

    logic                            busy_reg;
    logic                            done_reg;
    logic                            zero_reg;
    logic [tak_pkg::CSW-1:0]         i_reg;
    logic signed [tak_pkg::CXW-1:0]  x_reg;
    logic signed [tak_pkg::CXW-1:0]  y_reg;
    logic signed [tak_pkg::CZW-1:0]  z_reg;

    logic signed [16:0]              xv0;
    logic signed [16:0]              yv0;
    logic signed [16:0]              xv;
    logic signed [16:0]              yv;
    logic signed [tak_pkg::CZW-1:0]  z0;
    logic signed [tak_pkg::CXW-1:0]  dx;
    logic signed [tak_pkg::CXW-1:0]  dy;
    logic signed [tak_pkg::CZW-1:0]  stp;
    logic signed [tak_pkg::CZW-1:0]  zr;

    always_comb
    begin
        xv0 = 17'(vert);
        yv0 = -17'(lat);
        xv  = vert[15] ? -xv0 : xv0;
        yv  = vert[15] ? -yv0 : yv0;
        if (vert[15])
            z0 = (lat <= 16'sd0) ? tak_pkg::PI_Q32 : -tak_pkg::PI_Q32;
        else
            z0 = '0;
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        stp = signed'(tak_pkg::CZW'(tak_pkg::atan_step(i_reg)));
        zr  = (z_reg + tak_pkg::CZW'(8)) >>> 4;
        meas = zero_reg ? '0 : zr[tak_pkg::MEW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (i_reg == tak_pkg::CSW'(tak_pkg::CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                i_reg <= i_reg + tak_pkg::CSW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (lat == 16'sd0) && (vert == 16'sd0);
            x_reg    <= tak_pkg::CXW'(xv) <<< 14;
            y_reg    <= tak_pkg::CXW'(yv) <<< 14;
            z_reg    <= z0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[tak_pkg::CXW-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + stp;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - stp;
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- src/tilt_angle_kalman_filter_top.sv -----
// Tilt angle Kalman filter top level: sequencer, filter state and configuration.
// Depends on tak_pkg, tak_mul, tak_div and tak_cordic.
//
// Usage:
//   Input channel (in_valid/in_ready): axis, accel_lateral, accel_vertical, gyro_rate.
//   Output channel (out_valid/out_ready): axis_out, angle_estimate, one per input.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while the block is idle.
//   One item is in work at a time; in_ready is high only while the sequencer idles.
//   The work of an item is done by the shared multiplier, ten rounded products,
//   and by the bit-serial divider, two 46-bit quotients (no quotients when the
//   innovation variance is not positive; a saturating gain ends its division
//   early). Then the CORDIC angle is picked up and the output register is loaded.
//   The CORDIC runs beside the predict step.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, the following item holds before write-back.
//   Reset: angles and biases zero, covariances identity, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module tilt_angle_kalman_filter_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               axis,
    input  wire logic signed [15:0] accel_lateral,
    input  wire logic signed [15:0] accel_vertical,
    input  wire logic signed [31:0] gyro_rate,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    axis_out,
    output logic signed [31:0]      angle_estimate,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [45:0]        cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AM,
        S_TP,
        S_M1,
        S_M2,
        S_DIV0,
        S_DIV1,
        S_WAITC,
        S_ANG,
        S_BIAS,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   issued_reg;
    logic   out_valid_reg;
    logic   axis_out_reg;
    logic signed [31:0] angle_out_reg;

    logic [31:0] t_reg;
    logic [45:0] q_ang_reg;
    logic [45:0] q_bias_reg;
    logic [45:0] r_meas_reg;

    logic signed [31:0]          angle_mem_reg [tak_pkg::NUM_AXES];
    logic signed [31:0]          bias_mem_reg  [tak_pkg::NUM_AXES];
    logic signed [tak_pkg::PW-1:0] cov_mem_reg [tak_pkg::NUM_AXES][4];

    logic [tak_pkg::AXW-1:0]       ax_reg;
    logic                          axbit_reg;
    logic signed [31:0]            gyro_reg;
    logic signed [31:0]            a_reg;
    logic signed [31:0]            b_reg;
    logic signed [tak_pkg::PW-1:0] p_reg [4];
    logic signed [31:0]            am_reg;
    logic signed [tak_pkg::PW-1:0] tp_reg;
    logic signed [tak_pkg::SW-1:0] acc_reg;
    logic signed [tak_pkg::PW-1:0] n00_reg;
    logic signed [tak_pkg::PW-1:0] n01_reg;
    logic signed [tak_pkg::PW-1:0] n10_reg;
    logic signed [tak_pkg::PW-1:0] n11_reg;
    logic signed [tak_pkg::PW:0]   s_reg;
    logic signed [tak_pkg::PW-1:0] k0_reg;
    logic signed [tak_pkg::PW-1:0] k1_reg;
    logic signed [tak_pkg::EW-1:0] e_reg;
    logic signed [31:0]            ang_new_reg;
    logic signed [31:0]            bias_new_reg;
    logic signed [tak_pkg::PW-1:0] np_reg [4];

    tak_pkg::mul_req_t              mreq;
    tak_pkg::div_req_t              dreq;
    logic                           mul_done;
    logic signed [tak_pkg::MRW-1:0] mul_res;
    logic                           div_done;
    logic signed [tak_pkg::PW-1:0]  div_q;
    logic                           cordic_done;
    logic signed [tak_pkg::MEW-1:0] meas;

    logic                           mul_state;
    logic                           div_state;
    logic                           accept;
    logic                           finish;
    logic                           s_pos;
    logic [tak_pkg::AXW-1:0]        ax_next;
    logic signed [tak_pkg::SW-1:0]  mres_x;
    logic signed [tak_pkg::PW-1:0]  n00_c;
    logic signed [tak_pkg::MW-1:0]  t_op;
    logic signed [32:0]             gdiff;

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign finish    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign s_pos     = !s_reg[tak_pkg::PW] && (s_reg != '0);
    assign ax_next   = (tak_pkg::NUM_AXES > 1) ? tak_pkg::AXW'(axis) : '0;
    assign mres_x    = tak_pkg::SW'(mul_res);
    assign n00_c     = tak_pkg::sat48(acc_reg + mres_x);
    assign t_op      = signed'(tak_pkg::MW'(t_reg));
    assign gdiff     = 33'(gyro_reg) - 33'(b_reg);

    always_comb
    begin
        mreq.sh   = tak_pkg::SH32;
        mreq.a    = '0;
        mreq.b    = t_op;
        mul_state = 1'b1;
        unique case (state_reg)
            S_AM:    mreq.a = tak_pkg::MW'(gdiff) <<< 4;
            S_TP:    mreq.a = tak_pkg::MW'(p_reg[3]);
            S_M1:    mreq.a = tak_pkg::MW'(p_reg[1]) + tak_pkg::MW'(p_reg[2]);
            S_M2:    mreq.a = tak_pkg::MW'(tp_reg);
            S_ANG:
            begin
                mreq.a  = tak_pkg::MW'(k0_reg);
                mreq.b  = tak_pkg::MW'(e_reg);
                mreq.sh = tak_pkg::SH46;
            end
            S_BIAS:
            begin
                mreq.a  = tak_pkg::MW'(k1_reg);
                mreq.b  = tak_pkg::MW'(e_reg);
                mreq.sh = tak_pkg::SH50;
            end
            S_P0:
            begin
                mreq.a  = tak_pkg::MW'(k0_reg);
                mreq.b  = tak_pkg::MW'(n00_reg);
                mreq.sh = tak_pkg::SH46;
            end
            S_P1:
            begin
                mreq.a  = tak_pkg::MW'(k0_reg);
                mreq.b  = tak_pkg::MW'(n01_reg);
                mreq.sh = tak_pkg::SH46;
            end
            S_P2:
            begin
                mreq.a  = tak_pkg::MW'(k1_reg);
                mreq.b  = tak_pkg::MW'(n00_reg);
                mreq.sh = tak_pkg::SH46;
            end
            S_P3:
            begin
                mreq.a  = tak_pkg::MW'(k1_reg);
                mreq.b  = tak_pkg::MW'(n01_reg);
                mreq.sh = tak_pkg::SH46;
            end
            default: mul_state = 1'b0;
        endcase
        mreq.start = mul_state && !issued_reg;

        div_state  = ((state_reg == S_DIV0) || (state_reg == S_DIV1)) && s_pos;
        dreq.num   = (state_reg == S_DIV1) ? n10_reg : n00_reg;
        dreq.den   = s_reg[tak_pkg::PW-1:0];
        dreq.start = div_state && !issued_reg;
    end

    tak_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .res   (mul_res)
    );

    tak_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .q     (div_q)
    );

    tak_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .lat   (accel_lateral),
        .vert  (accel_vertical),
        .done  (cordic_done),
        .meas  (meas)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            axis_out_reg  <= 1'b0;
            angle_out_reg <= '0;
        end
        else
        begin
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (mreq.start || dreq.start)
                issued_reg <= 1'b1;
            else if (mul_done || div_done)
                issued_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:  if (accept) state_reg <= S_AM;
                S_AM:    if (mul_done) state_reg <= S_TP;
                S_TP:    if (mul_done) state_reg <= S_M1;
                S_M1:    if (mul_done) state_reg <= S_M2;
                S_M2:    if (mul_done) state_reg <= S_DIV0;
                S_DIV0:
                begin
                    if (!s_pos)
                        state_reg <= S_WAITC;
                    else if (div_done)
                        state_reg <= S_DIV1;
                end
                S_DIV1:  if (div_done) state_reg <= S_WAITC;
                S_WAITC: if (cordic_done) state_reg <= S_ANG;
                S_ANG:   if (mul_done) state_reg <= S_BIAS;
                S_BIAS:  if (mul_done) state_reg <= S_P0;
                S_P0:    if (mul_done) state_reg <= S_P1;
                S_P1:    if (mul_done) state_reg <= S_P2;
                S_P2:    if (mul_done) state_reg <= S_P3;
                S_P3:    if (mul_done) state_reg <= S_DONE;
                S_DONE:
                begin
                    if (finish)
                    begin
                        state_reg     <= S_IDLE;
                        axis_out_reg  <= axbit_reg;
                        angle_out_reg <= ang_new_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // working values of the item in progress
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg    <= ax_next;
            axbit_reg <= axis;
            gyro_reg  <= gyro_rate;
            a_reg     <= angle_mem_reg[ax_next];
            b_reg     <= bias_mem_reg[ax_next];
            for (int j = 0; j < 4; j++)
                p_reg[j] <= cov_mem_reg[ax_next][j];
        end
        if (mul_done)
        begin
            unique case (state_reg)
                S_AM:
                    am_reg <= tak_pkg::sat32(tak_pkg::SW'(a_reg) + mres_x);
                S_TP:
                begin
                    tp_reg  <= mul_res[tak_pkg::PW-1:0];
                    n01_reg <= tak_pkg::sat48(tak_pkg::SW'(p_reg[1]) - mres_x);
                    n10_reg <= tak_pkg::sat48(tak_pkg::SW'(p_reg[2]) - mres_x);
                    n11_reg <= tak_pkg::sat48(tak_pkg::SW'(p_reg[3])
                                              + signed'(tak_pkg::SW'(q_bias_reg)));
                end
                S_M1:
                    acc_reg <= tak_pkg::SW'(p_reg[0]) + signed'(tak_pkg::SW'(q_ang_reg))
                               - mres_x;
                S_M2:
                begin
                    n00_reg <= n00_c;
                    s_reg   <= (tak_pkg::PW + 1)'(n00_c)
                               + signed'((tak_pkg::PW + 1)'(r_meas_reg));
                end
                S_ANG:
                    ang_new_reg <= tak_pkg::sat32(tak_pkg::SW'(am_reg) + mres_x);
                S_BIAS:
                    bias_new_reg <= tak_pkg::sat32(tak_pkg::SW'(b_reg) + mres_x);
                S_P0: np_reg[0] <= tak_pkg::sat48(tak_pkg::SW'(n00_reg) - mres_x);
                S_P1: np_reg[1] <= tak_pkg::sat48(tak_pkg::SW'(n01_reg) - mres_x);
                S_P2: np_reg[2] <= tak_pkg::sat48(tak_pkg::SW'(n10_reg) - mres_x);
                S_P3: np_reg[3] <= tak_pkg::sat48(tak_pkg::SW'(n11_reg) - mres_x);
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_DIV0)
        begin
            if (!s_pos)
            begin
                k0_reg <= '0;
                k1_reg <= '0;
            end
            else if (div_done)
            begin
                k0_reg <= div_q;
            end
        end
        if (state_reg == S_DIV1 && div_done)
            k1_reg <= div_q;
        if (state_reg == S_WAITC && cordic_done)
            e_reg <= tak_pkg::EW'(meas) - tak_pkg::EW'(am_reg);
    end

    // filter banks and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tak_pkg::NUM_AXES; i++)
            begin
                angle_mem_reg[i]  <= '0;
                bias_mem_reg[i]   <= '0;
                cov_mem_reg[i][0] <= tak_pkg::P_ONE;
                cov_mem_reg[i][1] <= '0;
                cov_mem_reg[i][2] <= '0;
                cov_mem_reg[i][3] <= tak_pkg::P_ONE;
            end
            t_reg      <= 32'd21474836;
            q_ang_reg  <= 46'd7037;
            q_bias_reg <= 46'd7037;
            r_meas_reg <= 46'd7036874418;
        end
        else
        begin
            if (finish)
            begin
                angle_mem_reg[ax_reg] <= ang_new_reg;
                bias_mem_reg[ax_reg]  <= bias_new_reg;
                for (int j = 0; j < 4; j++)
                    cov_mem_reg[ax_reg][j] <= np_reg[j];
            end
            if (cfg_valid)
            begin
                unique case (tak_pkg::cfg_reg_t'(cfg_index))
                    tak_pkg::REG_PERIOD:  t_reg      <= cfg_data[31:0];
                    tak_pkg::REG_ANGLE_Q: q_ang_reg  <= cfg_data;
                    tak_pkg::REG_BIAS_Q:  q_bias_reg <= cfg_data;
                    tak_pkg::REG_MEAS_R:  r_meas_reg <= cfg_data;
                endcase
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign axis_out       = axis_out_reg;
    assign angle_estimate = angle_out_reg;

endmodule

`default_nettype wire
